// ===== src/nearest_palette_color_unit_defines.svh =====
// assertion macros used by nearest_palette_color_unit.sv
`ifndef NEAREST_PALETTE_COLOR_UNIT_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_UNIT_DEFINES_SVH

// plain clocked check, off during reset
`define NPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define NPC_ASSERT_IMPL(label, ante, cons, msg) \
  `NPC_ASSERT(label, (ante) |-> (cons), msg)

// antecedent implies consequent in the next cycle
`define NPC_ASSERT_NEXT(label, ante, cons, msg) \
  `NPC_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== src/npc_pkg.sv =====
package npc_pkg;

  localparam int unsigned STORE_DEPTH = 32;
  localparam int unsigned FIXED_COUNT = 32;
  localparam int unsigned IDX_W       = 5;
  localparam int unsigned DIST_W      = 18;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // larger than any real distance, so the first searched entry always wins
  localparam logic [DIST_W-1:0] DIST_INIT = '1;
  localparam logic [DIST_W-1:0] DIST_MAX  = 18'd195075;
  // worst case distance to the nearest fixed entry: 42^2 + 42^2 + 127^2
  localparam logic [DIST_W-1:0] FIXED_DIST_MAX = 18'd19657;

  localparam logic [7:0] LEVEL4 [4] = '{8'd0, 8'd85, 8'd170, 8'd255};
  localparam logic [7:0] LEVEL2 [2] = '{8'd0, 8'd255};

  typedef struct packed {
    logic       operation;
    logic [4:0] entry_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  best_index;
    logic [DIST_W-1:0] best_distance;
  } out_item_t;

  // what one cell hands to the next
  typedef struct packed {
    logic              valid;
    in_item_t          item;
    logic [IDX_W-1:0]  best_index;
    logic [DIST_W-1:0] best_distance;
  } chain_t;

  function automatic logic [23:0] fixed_rgb(input logic [IDX_W-1:0] idx);
    return {LEVEL4[idx[4:3]], LEVEL4[idx[2:1]], LEVEL2[idx[0]]};
  endfunction

endpackage

// ===== src/npc_cell.sv =====
module npc_cell #(
  parameter int unsigned INDEX  = 0,
  parameter bit          LOADED = 1'b1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            sel_i,
  input  npc_pkg::chain_t chain_i,
  output npc_pkg::chain_t chain_o
);

  localparam logic [npc_pkg::IDX_W-1:0] IDX = npc_pkg::IDX_W'(INDEX);

  logic [23:0]               entry_q;
  logic                      wr_hit;
  logic [23:0]               color;
  logic [7:0]                dr, dg, db;
  logic [15:0]               sr, sg, sb;
  logic [npc_pkg::DIST_W-1:0] dist_d, dist_q;
  logic                      cand_d, cand_q;
  npc_pkg::chain_t           s1_q, s2_d, s2_q;

  assign wr_hit = LOADED && chain_i.valid && (chain_i.item.operation == npc_pkg::OP_WRITE)
                  && (chain_i.item.entry_index == IDX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (en_i && wr_hit) begin
      entry_q <= {chain_i.item.red, chain_i.item.green, chain_i.item.blue};
    end
  end

  assign color = sel_i ? entry_q : npc_pkg::fixed_rgb(IDX);

  // stage 1: squared distance to this cell's color
  always_comb begin
    dr = (color[23:16] >= chain_i.item.red) ? color[23:16] - chain_i.item.red
                                           : chain_i.item.red - color[23:16];
    dg = (color[15:8] >= chain_i.item.green) ? color[15:8] - chain_i.item.green
                                            : chain_i.item.green - color[15:8];
    db = (color[7:0] >= chain_i.item.blue) ? color[7:0] - chain_i.item.blue
                                          : chain_i.item.blue - color[7:0];
    sr = 16'(dr) * 16'(dr);
    sg = 16'(dg) * 16'(dg);
    sb = 16'(db) * 16'(db);
    dist_d = npc_pkg::DIST_W'(sr) + npc_pkg::DIST_W'(sg) + npc_pkg::DIST_W'(sb);
    cand_d = sel_i ? LOADED : 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= '0;
      dist_q <= '0;
      cand_q <= 1'b0;
    end else if (en_i) begin
      s1_q   <= chain_i;
      dist_q <= dist_d;
      cand_q <= cand_d;
    end
  end

  // stage 2: keep the running best, strict less keeps the lower index on ties
  always_comb begin
    s2_d = s1_q;
    if (s1_q.valid && (s1_q.item.operation == npc_pkg::OP_LOOKUP) && cand_q
        && (dist_q < s1_q.best_distance)) begin
      s2_d.best_index    = IDX;
      s2_d.best_distance = dist_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else if (en_i) begin
      s2_q <= s2_d;
    end
  end

  assign chain_o = s2_q;

endmodule

// ===== src/nearest_palette_color_unit.sv =====
// nearest palette color unit
// in channel: in_valid_i / in_stall_o carry one item per transfer. a write item
//   (operation 0) stores red, green, blue into entry entry_index of the loaded
//   palette and gives no result; a lookup item (operation 1) gives one result.
// out channel: out_valid_o / out_stall_i carry best_index and best_distance.
// cfg channel: cfg_valid_i / cfg_ready_o write palette_select (0 fixed 4x4x2
//   palette, 1 loaded palette); ready is always high, write it only when idle.
// the pixel walks a row of 32 palette cells, two register stages per cell,
//   each cell folding its own distance into the running best.
// path: a lookup passes both register stages of each cell in turn, then the
//   output register, before it shows on out_valid_o; the first register loads
//   at the edge that accepts the lookup.
// throughput: one item per cycle unless stalled, writes and lookups mixed
//   freely; a write is seen by every lookup behind it and by none ahead of it.
// stall: while a result waits in the output register under out_stall_i the
//   whole row freezes and in_stall_o is raised.
// reset: row emptied, loaded palette cleared to black, fixed palette selected.
`include "nearest_palette_color_unit_defines.svh"

module nearest_palette_color_unit #(
  parameter int unsigned PALETTE_SIZE = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  npc_pkg::in_item_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output npc_pkg::out_item_t   out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_data_i
);

  // only the entries that entry_index can reach exist
  localparam int unsigned LOADED_COUNT =
    (PALETTE_SIZE < npc_pkg::STORE_DEPTH) ? PALETTE_SIZE : npc_pkg::STORE_DEPTH;
  localparam int unsigned CELLS = npc_pkg::FIXED_COUNT;

  logic                       palette_select_q;
  logic                       en;
  npc_pkg::chain_t            chain [CELLS+1];
  logic                       out_valid_d, out_valid_q;
  npc_pkg::out_item_t         out_data_d, out_data_q;
  logic                       tail_write;
  logic                       fixed_out;
  logic [npc_pkg::DIST_W-1:0] out_dist;

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_select_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      palette_select_q <= cfg_data_i;
    end
  end

  // row advances unless a finished result is held back
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // head of the row: nothing found yet
  assign chain[0].valid         = in_valid_i;
  assign chain[0].item          = in_data_i;
  assign chain[0].best_index    = '0;
  assign chain[0].best_distance = npc_pkg::DIST_INIT;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    npc_cell #(
      .INDEX  (k),
      .LOADED (k < LOADED_COUNT)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .sel_i   (palette_select_q),
      .chain_i (chain[k]),
      .chain_o (chain[k+1])
    );
  end

  // output register, only lookups leave the row
  always_comb begin
    out_valid_d              = chain[CELLS].valid
                               && (chain[CELLS].item.operation == npc_pkg::OP_LOOKUP);
    out_data_d.best_index    = chain[CELLS].best_index;
    out_data_d.best_distance = chain[CELLS].best_distance;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // shorthands for the checks below
  assign tail_write = chain[CELLS].valid && (chain[CELLS].item.operation == npc_pkg::OP_WRITE);
  assign fixed_out  = out_valid_q && !palette_select_q;
  assign out_dist   = out_data_q.best_distance;

  // a held result freezes the tail of the row
  `NPC_ASSERT_NEXT(a_tail_frozen, !en, $stable(chain[CELLS]), "row moved under stall")
  // a write leaving the row never makes a result
  `NPC_ASSERT_NEXT(a_write_silent, en && tail_write, !out_valid_q, "write made a result")
  // every result has a real distance
  `NPC_ASSERT_IMPL(a_dist_range, out_valid_q, out_dist <= npc_pkg::DIST_MAX, "bad distance")
  // the fixed palette is never farther than its grid spacing allows
  `NPC_ASSERT_IMPL(a_fixed_bound, fixed_out, out_dist <= npc_pkg::FIXED_DIST_MAX, "fixed too far")

endmodule
